[hw/rtl/imh_pkg.sv]
// Shared types, constants and codes for the indexed min-heap.
package imh_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int VTX_W = 8;
	localparam int WGT_W = 32;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int NODE_W = CNT_W;
	localparam int POS_W = $clog2(MAX_VERTICES);
	localparam int LEVELS = NODE_W;
	localparam int LVL_W = $clog2(LEVELS);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOWER = 2'd1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_DUP = 3'd2;
	localparam logic [2:0] ST_ABSENT = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic [VTX_W-1:0] vtx;
		logic signed [WGT_W-1:0] wgt;
	} entry_t;

	// One heap access per cycle: a read and a write, both by 1-based node number.
	typedef struct packed {
		logic rd_en;
		logic [NODE_W-1:0] rd_node;
		logic wr_en;
		logic [NODE_W-1:0] wr_node;
		entry_t wr_data;
	} heap_req_t;

endpackage

[hw/rtl/imh_ram.sv]
// Generic single-write, single-read memory with registered read data.
module imh_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/imh_cell.sv]
// One heap level: decodes node numbers for its level and forwards read data down the chain.
module imh_cell import imh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LVL_W-1:0] lvl,
	input  heap_req_t        req,
	output logic             rd_en,
	output logic [POS_W-1:0] rd_addr,
	output logic             wr_en,
	output logic [POS_W-1:0] wr_addr,
	input  entry_t           ram_rdata,
	input  entry_t           chain_in,
	output entry_t           chain_out
);

	logic rd_hit;
	logic wr_hit;
	logic hit_q;
	logic [NODE_W-1:0] lead;

	// A node belongs to level k when its top set bit is bit k.
	assign lead = NODE_W'(1) << lvl;
	assign rd_hit = (req.rd_node >> lvl) == NODE_W'(1);
	assign wr_hit = (req.wr_node >> lvl) == NODE_W'(1);
	assign rd_en = req.rd_en && rd_hit;
	assign wr_en = req.wr_en && wr_hit;
	assign rd_addr = POS_W'(req.rd_node ^ lead);
	assign wr_addr = POS_W'(req.wr_node ^ lead);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= rd_en;
		end
	end

	assign chain_out = hit_q ? ram_rdata : chain_in;

endmodule

[hw/rtl/indexed_min_heap_top.sv]
// Top level of the indexed min-heap: sequencer, position memory and the chain of level cells.
// An item that fails its checks goes to the output after decoding, or after a position
// lookup for a queued vertex; an insert or weight decrease climbs the heap level by level,
// an extract sinks level by level. One item is in work at a time, as the input is ready
// only while the sequencer is idle. Reset clears the membership flags and the entry count
// at once; the heap and position memories need no clearing pass.
module indexed_min_heap_top import imh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // vertex[7:0], weight[39:8]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_vertex[7:0], out_weight[39:8], entry_count[48:40]
	output logic [3:0]  m_tuser    // status[2:0], was_queued[3]
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_POS  = 4'd2;
	localparam logic [3:0] S_ENT  = 4'd3;
	localparam logic [3:0] S_EXT1 = 4'd4;
	localparam logic [3:0] S_EXT2 = 4'd5;
	localparam logic [3:0] S_UP   = 4'd6;
	localparam logic [3:0] S_UPC  = 4'd7;
	localparam logic [3:0] S_DN   = 4'd8;
	localparam logic [3:0] S_DNL  = 4'd9;
	localparam logic [3:0] S_DNR  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [3:0] state_q;
	logic [1:0] op_q;
	logic [VTX_W-1:0] v_q;
	logic signed [WGT_W-1:0] w_q;
	logic [NODE_W-1:0] node_q;
	entry_t x_q;
	entry_t lent_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAX_VERTICES-1:0] flag_q;

	logic [VTX_W-1:0] ov_q;
	logic [WGT_W-1:0] ow_q;
	logic [2:0] st_q;
	logic wq_q;

	logic m_tvalid_q;
	logic [55:0] m_tdata_q;
	logic [3:0] m_tuser_q;

	heap_req_t hreq;
	entry_t hrd;
	logic pre;
	logic pwe;
	logic [POS_W-1:0] praddr;
	logic [POS_W-1:0] pwaddr;
	logic [POS_W-1:0] pwdata;
	logic [POS_W-1:0] prd;

	logic in_range;
	logic is_queued;
	logic [NODE_W:0] lnode;
	logic [NODE_W:0] rnode;
	logic l_exists;
	logic r_exists;
	entry_t l_ent;
	logic l_win;
	logic r_win;
	logic signed [WGT_W-1:0] best_w;
	logic dn_swap;
	entry_t child;
	logic [NODE_W-1:0] child_node;
	logic up_swap;
	logic out_free;

	entry_t chain [LEVELS+1];

	assign in_range = CNT_W'(v_q) < CNT_W'(MAX_VERTICES);
	assign is_queued = in_range && flag_q[POS_W'(v_q)];
	assign out_free = !m_tvalid_q || m_tready;

	// Children of node n are 2n and 2n+1 in 1-based numbering.
	assign lnode = {node_q, 1'b0};
	assign rnode = {node_q, 1'b1};
	assign l_exists = lnode <= (NODE_W+1)'(cnt_q);
	assign r_exists = rnode <= (NODE_W+1)'(cnt_q);

	// The left child wins a tie with the right; a move needs a strictly smaller key.
	assign l_ent = (state_q == S_DNR) ? lent_q : hrd;
	assign l_win = $signed(l_ent.wgt) < $signed(x_q.wgt);
	assign best_w = l_win ? l_ent.wgt : x_q.wgt;
	assign r_win = (state_q == S_DNR) && ($signed(hrd.wgt) < $signed(best_w));
	assign dn_swap = l_win || r_win;
	assign child = r_win ? hrd : l_ent;
	assign child_node = r_win ? NODE_W'(rnode) : NODE_W'(lnode);
	assign up_swap = $signed(x_q.wgt) < $signed(hrd.wgt);

	// Heap and position memory requests for the current step.
	always_comb begin
		hreq = '0;
		pre = 1'b0;
		praddr = POS_W'(v_q);
		pwe = 1'b0;
		pwaddr = x_q.vtx;
		pwdata = POS_W'(node_q - NODE_W'(1));
		hreq.wr_node = node_q;
		hreq.wr_data = x_q;
		unique case (state_q)
			S_DEC: begin
				if (op_q[1]) begin
					hreq.rd_en = cnt_q != '0;
					hreq.rd_node = NODE_W'(1);
				end else begin
					pre = is_queued;
				end
			end
			S_POS: begin
				hreq.rd_en = 1'b1;
				hreq.rd_node = NODE_W'(prd) + NODE_W'(1);
			end
			S_EXT1: begin
				hreq.rd_en = cnt_q > CNT_W'(1);
				hreq.rd_node = NODE_W'(cnt_q);
			end
			S_UP: begin
				if (node_q == NODE_W'(1)) begin
					hreq.wr_en = 1'b1;
					pwe = 1'b1;
				end else begin
					hreq.rd_en = 1'b1;
					hreq.rd_node = node_q >> 1;
				end
			end
			S_UPC: begin
				hreq.wr_en = 1'b1;
				pwe = 1'b1;
				if (up_swap) begin
					hreq.wr_data = hrd;
					pwaddr = hrd.vtx;
				end
			end
			S_DN: begin
				if (l_exists) begin
					hreq.rd_en = 1'b1;
					hreq.rd_node = NODE_W'(lnode);
				end else begin
					hreq.wr_en = 1'b1;
					pwe = 1'b1;
				end
			end
			S_DNL, S_DNR: begin
				if (state_q == S_DNL && r_exists) begin
					hreq.rd_en = 1'b1;
					hreq.rd_node = NODE_W'(rnode);
				end else begin
					hreq.wr_en = 1'b1;
					pwe = 1'b1;
					if (dn_swap) begin
						hreq.wr_data = child;
						pwaddr = child.vtx;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Chain of level cells; read data passes from cell to cell toward the end of the row.
	assign chain[0] = '0;
	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		localparam int AW = (k == 0) ? 1 : k;
		logic rd_en;
		logic wr_en;
		logic [POS_W-1:0] rd_addr;
		logic [POS_W-1:0] wr_addr;
		entry_t rdata;

		imh_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.lvl       (LVL_W'(k)),
			.req       (hreq),
			.rd_en     (rd_en),
			.rd_addr   (rd_addr),
			.wr_en     (wr_en),
			.wr_addr   (wr_addr),
			.ram_rdata (rdata),
			.chain_in  (chain[k]),
			.chain_out (chain[k+1])
		);

		imh_ram #(.AW(AW), .DW($bits(entry_t))) u_ram (
			.clk   (clk),
			.we    (wr_en),
			.waddr (wr_addr[AW-1:0]),
			.wdata (hreq.wr_data),
			.re    (rd_en),
			.raddr (rd_addr[AW-1:0]),
			.rdata (rdata)
		);
	end
	assign hrd = chain[LEVELS];

	// Heap slot of each queued vertex, stored 0-based.
	imh_ram #(.AW(POS_W), .DW(POS_W)) u_pos (
		.clk   (clk),
		.we    (pwe),
		.waddr (pwaddr),
		.wdata (pwdata),
		.re    (pre),
		.raddr (praddr),
		.rdata (prd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			flag_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// A new result may replace the one being taken in the same cycle.
			if (state_q == S_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (op_q[1]) begin
						state_q <= (cnt_q == '0) ? S_FIN : S_EXT1;
					end else if (!in_range) begin
						state_q <= S_FIN;
					end else if (is_queued) begin
						state_q <= S_POS;
					end else if (op_q == OP_LOWER) begin
						state_q <= S_FIN;
					end else if (cnt_q >= CNT_W'(MAX_VERTICES)) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
						flag_q[POS_W'(v_q)] <= 1'b1;
						state_q <= S_UP;
					end
				end
				S_POS: state_q <= S_ENT;
				S_ENT: begin
					state_q <= (op_q == OP_LOWER && $signed(w_q) < $signed(hrd.wgt)) ?
						S_UP : S_FIN;
				end
				S_EXT1: begin
					flag_q[POS_W'(hrd.vtx)] <= 1'b0;
					cnt_q <= cnt_q - CNT_W'(1);
					state_q <= (cnt_q > CNT_W'(1)) ? S_EXT2 : S_FIN;
				end
				S_EXT2: state_q <= S_DN;
				S_UP: state_q <= (node_q == NODE_W'(1)) ? S_FIN : S_UPC;
				S_UPC: state_q <= up_swap ? S_UP : S_FIN;
				S_DN: state_q <= l_exists ? S_DNL : S_FIN;
				S_DNL: begin
					if (r_exists) begin
						state_q <= S_DNR;
					end else begin
						state_q <= dn_swap ? S_DN : S_FIN;
					end
				end
				S_DNR: state_q <= dn_swap ? S_DN : S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and result fields; payload only, no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q <= s_tuser;
				v_q <= s_tdata[7:0];
				w_q <= s_tdata[39:8];
			end
			S_DEC: begin
				ov_q <= op_q[1] ? '0 : v_q;
				x_q <= '{vtx: v_q, wgt: w_q};
				node_q <= NODE_W'(cnt_q) + NODE_W'(1);
				if (op_q[1]) begin
					ow_q <= '0;
					wq_q <= 1'b0;
					st_q <= (cnt_q == '0) ? ST_EMPTY : ST_OK;
				end else if (!in_range) begin
					ow_q <= '0;
					wq_q <= 1'b0;
					st_q <= (op_q == OP_INSERT) ? ST_FULL : ST_ABSENT;
				end else if (is_queued) begin
					ow_q <= '0;
					wq_q <= 1'b1;
					st_q <= (op_q == OP_INSERT) ? ST_DUP : ST_OK;
				end else if (op_q == OP_LOWER) begin
					ow_q <= '0;
					wq_q <= 1'b0;
					st_q <= ST_ABSENT;
				end else if (cnt_q >= CNT_W'(MAX_VERTICES)) begin
					ow_q <= '0;
					wq_q <= 1'b0;
					st_q <= ST_FULL;
				end else begin
					ow_q <= w_q;
					wq_q <= 1'b0;
					st_q <= ST_OK;
				end
			end
			S_POS: node_q <= NODE_W'(prd) + NODE_W'(1);
			S_ENT: begin
				ow_q <= (op_q == OP_LOWER && $signed(w_q) < $signed(hrd.wgt)) ?
					w_q : hrd.wgt;
			end
			S_EXT1: begin
				ov_q <= hrd.vtx;
				ow_q <= hrd.wgt;
				wq_q <= 1'b1;
			end
			S_EXT2: begin
				x_q <= hrd;
				node_q <= NODE_W'(1);
			end
			S_UPC: begin
				if (up_swap) begin
					node_q <= node_q >> 1;
				end
			end
			S_DNL: begin
				lent_q <= hrd;
				if (!r_exists && dn_swap) begin
					node_q <= child_node;
				end
			end
			S_DNR: begin
				if (dn_swap) begin
					node_q <= child_node;
				end
			end
			S_FIN: begin
				if (out_free) begin
					m_tdata_q <= {7'd0, cnt_q, ow_q, ov_q};
					m_tuser_q <= {wq_q, st_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	// The entry count always equals the number of queued vertices.
	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(flag_q) == 32'(cnt_q))
		else $error("entry count differs from membership flags");

	// The count never passes the capacity.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_VERTICES))
		else $error("entry count beyond capacity");

	// One item at a time: after an item is taken the input side closes.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in work");

	// An empty answer reports no entries.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:0] == ST_EMPTY) |-> (m_tdata[48:40] == 9'd0))
		else $error("empty status with entries left");

endmodule
